>>> rtl/core/cci_pkg.sv
// Shared types, widths and register codes of the cohort cell index iterator.
package cci_pkg;

    // Field widths.
    localparam int INDEX_BITS = 24;
    localparam int COUNT_BITS = 12;
    localparam int TRI_BITS   = 2;

    // Configuration port: eight 32-bit registers at byte addresses 4*i.
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = 3;
    localparam int APB_ADDR_BITS = REG_IDX_BITS + 2;

    // Divider bit counter and signed index sum widths.
    localparam int DIV_CNT_BITS = $clog2(INDEX_BITS);
    localparam int SUM_BITS     = INDEX_BITS + 3;

    // Packed stream widths.
    localparam int OUT_FIELD_BITS = INDEX_BITS + 2 * COUNT_BITS + TRI_BITS;
    localparam int S_TDATA_BITS   = ((INDEX_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS   = ((OUT_FIELD_BITS + 7) / 8) * 8;

    typedef logic [INDEX_BITS-1:0]      index_t;
    typedef logic [COUNT_BITS-1:0]      count_t;
    typedef logic [TRI_BITS-1:0]        tri_t;
    typedef logic signed [SUM_BITS-1:0] sum_t;

    // Register indexes.
    localparam logic [REG_IDX_BITS-1:0] REG_MODE          = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_STEP_TIME     = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_STEP_AGE      = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_STEP_TRIANGLE = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_TIME_COUNT    = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_AGE_COUNT     = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_HAS_AGE       = 3'd6;
    localparam logic [REG_IDX_BITS-1:0] REG_OPEN_LAST_AGE = 3'd7;

    // Walk modes and item kinds.
    localparam logic MODE_PERIOD    = 1'b0;
    localparam logic MODE_COMPONENT = 1'b1;
    localparam logic KIND_ADVANCE   = 1'b0;
    localparam logic KIND_RESET     = 1'b1;

    // Triangle codes.
    localparam tri_t TRI_LOWER = 2'd1;
    localparam tri_t TRI_UPPER = 2'd2;

    localparam index_t INDEX_ONE = index_t'(1);
    localparam count_t COUNT_ONE = count_t'(1);
    localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

    // A stride of zero acts as one.
    function automatic index_t index_at_least_one(input index_t v);
        index_t r;
        r = (v == '0) ? INDEX_ONE : v;
        return r;
    endfunction

    // A count of zero acts as one.
    function automatic count_t count_at_least_one(input count_t v);
        count_t r;
        r = (v == '0) ? COUNT_ONE : v;
        return r;
    endfunction

    // Saturating increment of a position counter.
    function automatic count_t inc_count(input count_t v);
        count_t r;
        r = (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_ONE;
        return r;
    endfunction

    // Widen an unsigned index value into the signed sum width.
    function automatic sum_t to_sum(input index_t v);
        sum_t r;
        r = $signed({3'b000, v});
        return r;
    endfunction

endpackage

>>> rtl/core/cohort_cell_index_iterator.sv
// Cohort cell index iterator: sequencer, shared divider and step logic.
//
// Channel   Dir  Fields (low bit up)                                 Handshake
// s_*       in   tuser: kind; tdata: start_index                     s_tvalid/s_tready
// m_*       out  tdata: cell_index, time_pos, age_pos, triangle_pos; m_tvalid/m_tready
//                tlast: finished
// APB       in   registers 0..7 at byte address 4*i                  psel/penable, pready=1
//
// An advance word's result is loaded into the output register at the edge that
// accepts it. A reset word runs five passes of a shared restoring divider, then
// commits its result once the output register is empty or being drained. Input
// is accepted only while the sequencer is idle and the output register is empty
// or being drained. rst_n clears the configuration and the walk state to their
// reset values at once.
module cohort_cell_index_iterator (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cci_pkg::S_TDATA_BITS-1:0]  s_tdata,   // [23:0] start_index
    input  logic                              s_tuser,   // [0] kind
    // Output stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cci_pkg::M_TDATA_BITS-1:0]  m_tdata,   // [23:0] cell_index,
                                                         // [35:24] time_pos,
                                                         // [47:36] age_pos,
                                                         // [49:48] triangle_pos
    output logic                              m_tlast,   // finished
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cci_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [cci_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [cci_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready
);
    import cci_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam logic [2:0] PASS_TIME_QUO = 3'd0;
    localparam logic [2:0] PASS_TIME_REM = 3'd1;
    localparam logic [2:0] PASS_AGE_QUO  = 3'd2;
    localparam logic [2:0] PASS_AGE_REM  = 3'd3;
    localparam logic [2:0] PASS_TRI      = 3'd4;

    localparam logic [DIV_CNT_BITS-1:0] BIT_LAST = DIV_CNT_BITS'(INDEX_BITS - 1);
    localparam sum_t SUM_ONE = sum_t'(1);
    localparam sum_t SUM_MAX = $signed({3'b000, {INDEX_BITS{1'b1}}});

    // Configuration registers.
    logic   mode_reg;
    index_t step_time_reg;
    index_t step_age_reg;
    index_t step_tri_reg;
    count_t time_count_reg;
    count_t age_count_reg;
    logic   has_age_reg;
    logic   open_last_age_reg;

    // Walk state.
    index_t cur_index_reg;
    count_t cur_time_reg;
    count_t cur_age_reg;
    tri_t   cur_tri_reg;

    // Sequencer and divider.
    logic [1:0]              state_reg;
    logic [2:0]              pass_reg;
    logic [DIV_CNT_BITS-1:0] bit_reg;
    index_t                  rem_reg;
    index_t                  quo_reg;
    index_t                  s_reg;
    index_t                  start_reg;
    count_t                  der_time_reg;
    count_t                  der_age_reg;
    tri_t                    der_tri_reg;

    // Output register.
    logic   out_valid_reg;
    index_t out_index_reg;
    count_t out_time_reg;
    count_t out_age_reg;
    tri_t   out_tri_reg;
    logic   out_fin_reg;

    logic   cfg_write;
    logic   in_accept;
    logic   out_free;
    count_t nt;
    count_t na;
    index_t in_start;

    index_t                divisor;
    logic [INDEX_BITS:0]   div_shift;
    logic [INDEX_BITS:0]   div_diff;
    logic                  div_bit;
    index_t                rem_next;
    index_t                quo_next;

    sum_t   adv_sum;
    index_t adv_index;
    count_t adv_time;
    count_t adv_age;
    tri_t   adv_tri;
    logic   adv_fin;
    count_t t_inc;
    count_t a_inc;
    logic   oldest;

    count_t rst_time;
    count_t rst_age;
    tri_t   rst_tri;
    logic   rst_fin;

    logic   load_adv;
    logic   load_rst;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign in_accept = s_tvalid && s_tready;
    assign load_adv  = in_accept && (s_tuser == KIND_ADVANCE);
    assign load_rst  = (state_reg == ST_FIN) && out_free;
    assign nt        = count_at_least_one(time_count_reg);
    assign na        = count_at_least_one(age_count_reg);
    assign in_start  = index_at_least_one(s_tdata[INDEX_BITS-1:0]);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_PERIOD;
            step_time_reg     <= INDEX_ONE;
            step_age_reg      <= INDEX_ONE;
            step_tri_reg      <= INDEX_ONE;
            time_count_reg    <= COUNT_ONE;
            age_count_reg     <= COUNT_ONE;
            has_age_reg       <= 1'b1;
            open_last_age_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (paddr[APB_ADDR_BITS-1:2])
                REG_MODE:          mode_reg          <= pwdata[0];
                REG_STEP_TIME:     step_time_reg     <= pwdata[INDEX_BITS-1:0];
                REG_STEP_AGE:      step_age_reg      <= pwdata[INDEX_BITS-1:0];
                REG_STEP_TRIANGLE: step_tri_reg      <= pwdata[INDEX_BITS-1:0];
                REG_TIME_COUNT:    time_count_reg    <= pwdata[COUNT_BITS-1:0];
                REG_AGE_COUNT:     age_count_reg     <= pwdata[COUNT_BITS-1:0];
                REG_HAS_AGE:       has_age_reg       <= pwdata[0];
                REG_OPEN_LAST_AGE: open_last_age_reg <= pwdata[0];
                default:           ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        prdata = '0;
        unique case (paddr[APB_ADDR_BITS-1:2])
            REG_MODE:          prdata = APB_DATA_BITS'(mode_reg);
            REG_STEP_TIME:     prdata = APB_DATA_BITS'(step_time_reg);
            REG_STEP_AGE:      prdata = APB_DATA_BITS'(step_age_reg);
            REG_STEP_TRIANGLE: prdata = APB_DATA_BITS'(step_tri_reg);
            REG_TIME_COUNT:    prdata = APB_DATA_BITS'(time_count_reg);
            REG_AGE_COUNT:     prdata = APB_DATA_BITS'(age_count_reg);
            REG_HAS_AGE:       prdata = APB_DATA_BITS'(has_age_reg);
            REG_OPEN_LAST_AGE: prdata = APB_DATA_BITS'(open_last_age_reg);
            default:           prdata = '0;
        endcase
    end

    // Divisor for the current divider pass.
    always_comb
    begin
        unique case (pass_reg)
            PASS_TIME_QUO: divisor = index_at_least_one(step_time_reg);
            PASS_TIME_REM: divisor = INDEX_BITS'(nt);
            PASS_AGE_QUO:  divisor = index_at_least_one(step_age_reg);
            PASS_AGE_REM:  divisor = INDEX_BITS'(na);
            PASS_TRI:      divisor = index_at_least_one(step_tri_reg);
            default:       divisor = INDEX_ONE;
        endcase
    end

    // One restoring divider step: shift in a dividend bit and try a subtract.
    always_comb
    begin
        div_shift = {rem_reg, quo_reg[INDEX_BITS-1]};
        div_diff  = div_shift - {1'b0, divisor};
        div_bit   = !div_diff[INDEX_BITS];
        rem_next  = div_bit ? div_diff[INDEX_BITS-1:0] : div_shift[INDEX_BITS-1:0];
        quo_next  = {quo_reg[INDEX_BITS-2:0], div_bit};
    end

    // Advance step of the walk.
    always_comb
    begin
        t_inc     = inc_count(cur_time_reg);
        a_inc     = inc_count(cur_age_reg);
        oldest    = (cur_age_reg == na);
        adv_time  = cur_time_reg;
        adv_age   = cur_age_reg;
        adv_tri   = cur_tri_reg;
        adv_sum   = to_sum(cur_index_reg);
        adv_fin   = 1'b0;
        if (mode_reg == MODE_PERIOD)
        begin
            adv_time = t_inc;
            adv_sum  = to_sum(cur_index_reg) + to_sum(step_time_reg);
            if (has_age_reg && (cur_age_reg < na))
            begin
                adv_age = a_inc;
                adv_sum = adv_sum + to_sum(step_age_reg);
            end
            if (!has_age_reg)
            begin
                adv_age = COUNT_ONE;
            end
            adv_fin = (t_inc >= nt);
        end
        else if (has_age_reg)
        begin
            if (cur_tri_reg == TRI_LOWER)
            begin
                adv_time = t_inc;
                adv_sum  = to_sum(cur_index_reg) + to_sum(step_time_reg)
                           + to_sum(step_tri_reg);
                adv_tri  = TRI_UPPER;
                adv_fin  = open_last_age_reg ? ((t_inc == nt) && oldest) : oldest;
            end
            else if (oldest)
            begin
                // Open oldest group: stay in the upper triangle and move in time.
                adv_time = t_inc;
                adv_sum  = to_sum(cur_index_reg) + to_sum(step_time_reg);
                adv_fin  = (t_inc == nt);
            end
            else
            begin
                adv_age = a_inc;
                adv_sum = to_sum(cur_index_reg) + to_sum(step_age_reg)
                          - to_sum(step_tri_reg);
                adv_tri = TRI_LOWER;
                adv_fin = (cur_time_reg == nt);
            end
        end
        else
        begin
            adv_time = t_inc;
            adv_sum  = to_sum(cur_index_reg) + to_sum(step_time_reg);
            adv_age  = COUNT_ONE;
            adv_fin  = (t_inc == nt);
        end

        // The index saturates at both ends.
        if (adv_sum < SUM_ONE)
        begin
            adv_index = INDEX_ONE;
        end
        else if (adv_sum > SUM_MAX)
        begin
            adv_index = {INDEX_BITS{1'b1}};
        end
        else
        begin
            adv_index = adv_sum[INDEX_BITS-1:0];
        end
    end

    // Positions and finished flag after a reset word.
    always_comb
    begin
        rst_time = der_time_reg;
        rst_age  = has_age_reg ? der_age_reg : COUNT_ONE;
        rst_tri  = ((mode_reg == MODE_COMPONENT) && has_age_reg) ? der_tri_reg : TRI_LOWER;
        if ((mode_reg == MODE_PERIOD) || !has_age_reg)
        begin
            rst_fin = (mode_reg == MODE_PERIOD) ? (rst_time >= nt) : (rst_time == nt);
        end
        else if (rst_tri == TRI_LOWER)
        begin
            rst_fin = (rst_time == nt);
        end
        else if (open_last_age_reg)
        begin
            rst_fin = (rst_time == nt) && (rst_age == na);
        end
        else
        begin
            rst_fin = (rst_age == na);
        end
    end

    // Sequencer: divider passes for a reset word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pass_reg  <= PASS_TIME_QUO;
            bit_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept && (s_tuser == KIND_RESET))
                    begin
                        state_reg <= ST_DIV;
                        pass_reg  <= PASS_TIME_QUO;
                        bit_reg   <= '0;
                    end
                end
                ST_DIV:
                begin
                    if (bit_reg == BIT_LAST)
                    begin
                        bit_reg <= '0;
                        if (pass_reg == PASS_TRI)
                        begin
                            state_reg <= ST_FIN;
                        end
                        else
                        begin
                            pass_reg <= pass_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        bit_reg <= bit_reg + DIV_CNT_BITS'(1);
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Divider datapath and derived positions.
    always_ff @(posedge clk)
    begin
        if (in_accept && (s_tuser == KIND_RESET))
        begin
            start_reg <= in_start;
            s_reg     <= in_start - INDEX_ONE;
            quo_reg   <= in_start - INDEX_ONE;
            rem_reg   <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            if (bit_reg == BIT_LAST)
            begin
                rem_reg <= '0;
                unique case (pass_reg)
                    PASS_TIME_QUO, PASS_AGE_QUO:
                    begin
                        // Quotient feeds the remainder pass by the count.
                        quo_reg <= quo_next;
                    end
                    PASS_TIME_REM:
                    begin
                        der_time_reg <= rem_next[COUNT_BITS-1:0] + COUNT_ONE;
                        quo_reg      <= s_reg;
                    end
                    PASS_AGE_REM:
                    begin
                        der_age_reg <= rem_next[COUNT_BITS-1:0] + COUNT_ONE;
                        quo_reg     <= s_reg;
                    end
                    PASS_TRI:
                    begin
                        der_tri_reg <= quo_next[0] ? TRI_UPPER : TRI_LOWER;
                    end
                    default:
                    begin
                        quo_reg <= quo_next;
                    end
                endcase
            end
            else
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
            end
        end
    end

    // Walk state updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_index_reg <= INDEX_ONE;
            cur_time_reg  <= COUNT_ONE;
            cur_age_reg   <= COUNT_ONE;
            cur_tri_reg   <= TRI_LOWER;
        end
        else if (load_adv)
        begin
            cur_index_reg <= adv_index;
            cur_time_reg  <= adv_time;
            cur_age_reg   <= adv_age;
            cur_tri_reg   <= adv_tri;
        end
        else if (load_rst)
        begin
            cur_index_reg <= start_reg;
            cur_time_reg  <= rst_time;
            cur_age_reg   <= rst_age;
            cur_tri_reg   <= rst_tri;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_adv || load_rst)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (load_adv)
        begin
            out_index_reg <= adv_index;
            out_time_reg  <= adv_time;
            out_age_reg   <= has_age_reg ? adv_age : COUNT_ONE;
            out_tri_reg   <= (mode_reg == MODE_COMPONENT) ? adv_tri : TRI_LOWER;
            out_fin_reg   <= adv_fin;
        end
        else if (load_rst)
        begin
            out_index_reg <= start_reg;
            out_time_reg  <= rst_time;
            out_age_reg   <= rst_age;
            out_tri_reg   <= (mode_reg == MODE_COMPONENT) ? rst_tri : TRI_LOWER;
            out_fin_reg   <= rst_fin;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_fin_reg;
    assign m_tdata  = {{(M_TDATA_BITS - OUT_FIELD_BITS){1'b0}},
                       out_tri_reg, out_age_reg, out_time_reg, out_index_reg};

    // An advance word always yields a result on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == KIND_ADVANCE)) |=> m_tvalid)
        else $error("advance word produced no result");

    // A reset word starts the divider and blocks further input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == KIND_RESET)) |=>
        ((state_reg == ST_DIV) && !s_tready))
        else $error("reset word did not start the divider");

    // The reported index never leaves its one-based range.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[INDEX_BITS-1:0] != '0))
        else $error("cell index is zero");

    // The reported triangle is lower or upper.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((out_tri_reg == TRI_LOWER) || (out_tri_reg == TRI_UPPER)))
        else $error("triangle position out of range");

endmodule
